[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, codes and controller/datapath command types for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Capacity and derived widths
    localparam int DEPTH     = 8;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = IDX_W + 1;
    localparam int DATA_W    = 32;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

    // Operation codes
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic execute;   // apply the latched operation to the queue
    } t_dp_cmd;

endpackage

[rtl/deq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept a transaction, run it through the datapath, then
// strobe the result for one cycle.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_valid,
    output deq_pkg::t_dp_cmd o_dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Accept while idle or while the previous result is shown
    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive datapath commands and result strobe
    assign o_dp_cmd.capture = accept;
    assign o_dp_cmd.execute = (r_state == S_EXEC);
    assign o_valid          = (r_state == S_RESP);

endmodule

[rtl/deq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// Circular buffer storage with head index and entry count; computes the
// slot address, performs the push or pop and registers the result.
// ----------------------------------------------------------------------------
module deq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  deq_pkg::t_dp_cmd                  i_dp_cmd,
    input  logic [1:0]                        i_cmd,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_pop_value,
    output logic [1:0]                        o_status,
    output logic [deq_pkg::CNT_W-1:0]         o_occupancy
);

    // Latched transaction
    deq_pkg::t_cmd                r_cmd;
    logic [deq_pkg::DATA_W-1:0]   r_value;

    // Queue state
    logic [deq_pkg::IDX_W-1:0]    r_head;
    logic [deq_pkg::IDX_W-1:0]    n_head;
    logic [deq_pkg::CNT_W-1:0]    r_count;
    logic [deq_pkg::CNT_W-1:0]    n_count;

    // Storage
    logic [deq_pkg::DATA_W-1:0]   mem [deq_pkg::DEPTH];
    logic [deq_pkg::DATA_W-1:0]   r_rd_data;

    // Result registers
    deq_pkg::t_status             r_status;
    deq_pkg::t_status             n_status;
    logic                         r_pop_ok;
    logic                         n_pop_ok;

    // Address arithmetic
    logic                         empty;
    logic                         full;
    logic [deq_pkg::IDX_W-1:0]    head_dec;
    logic [deq_pkg::IDX_W-1:0]    head_inc;
    logic [deq_pkg::SUM_W-1:0]    tail_sum;
    logic [deq_pkg::IDX_W-1:0]    tail_idx;
    logic [deq_pkg::IDX_W-1:0]    back_idx;
    logic [deq_pkg::IDX_W-1:0]    addr;
    logic                         wr_en;

    function automatic logic [deq_pkg::SUM_W-1:0] SUM_W_EXT(
        input logic [deq_pkg::IDX_W-1:0] v
    );
        return deq_pkg::SUM_W'(v);
    endfunction

    function automatic logic [deq_pkg::SUM_W-1:0] SUM_W_EXT2(
        input logic [deq_pkg::CNT_W-1:0] v
    );
        return deq_pkg::SUM_W'(v);
    endfunction

    // Latch the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd   <= deq_pkg::t_cmd'(i_cmd);
            r_value <= i_push_value;
        end
    end

    // Wrap head and tail positions modulo the capacity
    assign empty    = (r_count == '0);
    assign full     = (r_count == deq_pkg::FULL_CNT);
    assign head_dec = (r_head == '0) ? deq_pkg::LAST_IDX : r_head - 1'b1;
    assign head_inc = (r_head == deq_pkg::LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_sum = SUM_W_EXT(r_head) + SUM_W_EXT2(r_count);
    assign tail_idx = (tail_sum >= deq_pkg::DEPTH_SUM)
                    ? deq_pkg::IDX_W'(tail_sum - deq_pkg::DEPTH_SUM)
                    : deq_pkg::IDX_W'(tail_sum);
    assign back_idx = (tail_idx == '0) ? deq_pkg::LAST_IDX : tail_idx - 1'b1;

    // Decode the operation
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = deq_pkg::ST_OK;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        addr     = r_head;
        unique case (r_cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
                addr = head_dec;
                if (full) begin
                    n_status = deq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                addr = tail_idx;
                if (full) begin
                    n_status = deq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                addr = r_head;
                if (empty) begin
                    n_status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_head   = head_inc;
                    n_count  = r_count - 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                addr = back_idx;
                if (empty) begin
                    n_status = deq_pkg::ST_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_status = deq_pkg::ST_OK;
            end
        endcase
    end

    // Advance head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_dp_cmd.execute) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Write or read one slot
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.execute) begin
            if (wr_en) begin
                mem[addr] <= r_value;
            end
            r_rd_data <= mem[addr];
        end
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.execute) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // Drive result ports; occupancy follows the updated count
    assign o_pop_value = r_pop_ok ? $signed(r_rd_data) : '0;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

endmodule

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity deque of signed 32-bit values with push/pop at both ends.
// ----------------------------------------------------------------------------
// Usage: drive i_cmd and i_push_value with start high; the transaction is
// taken at a rising edge where busy is low. After the execute state, o_valid
// is high for exactly one cycle with o_pop_value, o_status and o_occupancy;
// the result cannot be stalled, so capture it on that cycle. A new transaction
// may be started in the cycle the previous result is shown, but not while
// busy in the execute state, which addresses and accesses the single-port
// slot memory; the response state then presents the registered read data.
// Pushes on a full queue report overflow and store nothing; pops on an
// empty queue report underflow with a zero value.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic signed [deq_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_valid,
    output logic signed [deq_pkg::DATA_W-1:0] o_pop_value,
    output logic [1:0]                        o_status,
    output logic [deq_pkg::CNT_W-1:0]         o_occupancy
);

    deq_pkg::t_dp_cmd dp_cmd;

    // Sequencer
    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_dp_cmd (dp_cmd)
    );

    // Storage and pointer logic
    deq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

[rtl/deq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on transaction sequencing and result consistency.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [deq_pkg::DATA_W-1:0] o_pop_value,
    input logic [1:0]                        o_status,
    input logic [deq_pkg::CNT_W-1:0]         o_occupancy
);

    // Accepted transaction occupies the block next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Every busy cycle is followed by a result strobe with busy low
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("result strobe missing after busy");

    // Underflow leaves the queue empty and returns zero
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::ST_UNDERFLOW)
            |-> (o_occupancy == '0 && o_pop_value == '0))
        else $error("underflow result inconsistent");

    // Overflow only with a full queue
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::ST_OVERFLOW)
            |-> (o_occupancy == deq_pkg::FULL_CNT && o_pop_value == '0))
        else $error("overflow result inconsistent");

    // Occupancy never exceeds the capacity
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= deq_pkg::FULL_CNT))
        else $error("occupancy beyond capacity");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_pop_value (o_pop_value),
    .o_status    (o_status),
    .o_occupancy (o_occupancy)
);

[verif/double_ended_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the double-ended queue. It mirrors the circular
// buffer (head, count, slots) in a small class. Every accepted transaction
// is predicted there, and every o_valid strobe is compared field by field
// against the oldest prediction. Stimulus is a short directed run through
// empty, full, overflow, underflow and wrap-around, followed by random
// traffic. The random traffic swings the fill level between empty and full
// and uses random start gaps.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    // Expected fields of one result
    typedef struct {
        logic signed [DATA_W-1:0] pop_value;
        t_status                  status;
        logic [CNT_W-1:0]         occupancy;
    } t_deq_result;

    // Mirror of the deque contents plus the queue of results still due
    class deque_mirror;
        logic signed [DATA_W-1:0] slot_data [DEPTH];
        int                       head_pos;
        int                       fill;
        t_deq_result              results_due [$];
        int                       mismatches;
        int                       push_ok;
        int                       pop_ok;
        int                       overflows;
        int                       underflows;

        function new();
            head_pos    = 0;
            fill        = 0;
            mismatches  = 0;
            push_ok     = 0;
            pop_ok      = 0;
            overflows   = 0;
            underflows  = 0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Apply one accepted transaction and queue the result it must produce
        function void predict_operation(t_cmd op, logic signed [DATA_W-1:0] value);
            t_deq_result res;
            int          pos;
            res.pop_value = '0;
            res.status    = ST_OK;
            case (op)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        res.status = ST_OVERFLOW;
                        overflows++;
                    end else begin
                        if (op == CMD_PUSH_FRONT) begin
                            head_pos = (head_pos + DEPTH - 1) % DEPTH;
                            pos      = head_pos;
                        end else begin
                            pos = (head_pos + fill) % DEPTH;
                        end
                        slot_data[pos] = value;
                        fill++;
                        push_ok++;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        res.status = ST_UNDERFLOW;
                        underflows++;
                    end else begin
                        if (op == CMD_POP_FRONT) begin
                            res.pop_value = slot_data[head_pos];
                            head_pos      = (head_pos + 1) % DEPTH;
                        end else begin
                            pos           = (head_pos + fill - 1) % DEPTH;
                            res.pop_value = slot_data[pos];
                        end
                        fill--;
                        pop_ok++;
                    end
                end
            endcase
            res.occupancy = CNT_W'(fill);
            results_due.push_back(res);
        endfunction

        // Compare one strobed result with the oldest prediction
        function void compare_result(logic signed [DATA_W-1:0] pop_value,
                                     logic [1:0] status, logic [CNT_W-1:0] occupancy);
            t_deq_result want;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: result with none pending (pop %0d st %0d occ %0d)",
                             $realtime, pop_value, status, occupancy);
                return;
            end
            want = results_due.pop_front();
            if (pop_value !== want.pop_value || status !== want.status ||
                occupancy !== want.occupancy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: exp pop %0d st %0d occ %0d, got pop %0d st %0d occ %0d",
                             $realtime, want.pop_value, want.status, want.occupancy,
                             pop_value, status, occupancy);
            end
        endfunction
    endclass

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic [1:0]               i_cmd        = 2'd0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_pop_value;
    logic [1:0]               o_status;
    logic [CNT_W-1:0]         o_occupancy;

    deque_mirror mirror = new();
    bit          no_gaps = 1'b0;
    int          push_bias;

    double_ended_queue uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    // Clock generation
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Check every strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            mirror.compare_result(o_pop_value, o_status, o_occupancy);
    end

    // Present one transaction and hold it until the block takes it
    task automatic issue(t_cmd op, logic signed [DATA_W-1:0] value);
        int gap;
        if (!no_gaps && $urandom_range(99) < 14) begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (busy);
        mirror.predict_operation(op, value);
    endtask

    // Hold off until every outstanding result has been seen
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly full-range random data, sometimes a corner value
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Choose an operation; push_bias steers the fill level up or down
    function automatic t_cmd pick_op();
        if ($urandom_range(99) < push_bias)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    initial begin
        int bias_steps [5] = '{85, 50, 15, 95, 5};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow at both ends on an empty queue
        issue(CMD_POP_FRONT, 32'sh7FFF_FFFF);
        issue(CMD_POP_BACK, -32'sd1);
        // Fill from both ends with corner values, wrapping the head below zero
        issue(CMD_PUSH_FRONT, 32'sh8000_0000);
        issue(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        issue(CMD_PUSH_BACK, '0);
        issue(CMD_PUSH_BACK, -32'sd1);
        issue(CMD_PUSH_FRONT, 32'sh5555_5555);
        issue(CMD_PUSH_BACK, 32'shAAAA_AAAA);
        issue(CMD_PUSH_FRONT, 32'sh0000_0001);
        issue(CMD_PUSH_BACK, 32'shFFFF_FFFE);
        // Overflow on both ends when full
        issue(CMD_PUSH_FRONT, 32'sh1234_5678);
        issue(CMD_PUSH_BACK, 32'sh8765_4321);
        // Drain alternately from both ends, then underflow again
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_POP_FRONT, '0);
        issue(CMD_POP_BACK, '0);
        issue(CMD_POP_BACK, '0);
        // Single entry: push at back, take from front
        issue(CMD_PUSH_BACK, 32'sh0F0F_0F0F);
        issue(CMD_POP_FRONT, '0);
        drain();

        // Random traffic in blocks that push the fill level around
        for (int n = 0; n < 1750; n++) begin
            if (n % 40 == 0)
                push_bias = bias_steps[(n / 40) % 5];
            no_gaps = (n >= 600 && n < 900);
            if (n == 1000)
                drain();
            issue(pick_op(), pick_value());
        end
        drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d good pushes, %0d good pops, %0d overflows, %0d underflows.",
                 mirror.push_ok, mirror.pop_ok, mirror.overflows, mirror.underflows);
        $display("%0d mismatches, %0d results still outstanding.",
                 mirror.mismatches, mirror.pending());
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[double_ended_queue.f]
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
verif/double_ended_queue_tb.sv
